// File: rtl/core/spl_pkg.sv
`default_nettype none

package spl_pkg;

  // Table sizes and run limit
  localparam int KEY_DEPTH = 65536;
  localparam int POS_DEPTH = 262144;
  localparam int MAX_RUN   = 64;

  localparam int KEY_AW = $clog2(KEY_DEPTH);
  localparam int POS_AW = $clog2(POS_DEPTH);
  localparam int RUN_W  = $clog2(MAX_RUN + 1);

  // Field widths
  localparam int OFS_W    = 40;
  localparam int WORD_W   = 32;
  localparam int OCC_W    = 17;
  localparam int OCC_FRAC = 16;

  // Key table entry meaning "no hits"
  localparam logic [OFS_W-1:0] NO_HITS = 40'hff_ffff_ffff;
  localparam logic [OCC_W-1:0] OCC_ONE = 17'h1_0000;

  // Request codes
  localparam logic [1:0] REQ_KEY_WR = 2'd0;
  localparam logic [1:0] REQ_POS_WR = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_HIT   = 3'd0;
  localparam logic [2:0] ST_WRITE = 3'd1;
  localparam logic [2:0] ST_UNDEF = 3'd2;
  localparam logic [2:0] ST_ZERO  = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  // Configuration register indexes and reset values
  localparam logic REG_SEED_LENGTH = 1'b0;
  localparam logic REG_MAX_HITS    = 1'b1;
  localparam logic [5:0] SEED_LENGTH_RST = 6'd15;
  localparam logic [6:0] MAX_HITS_RST    = 7'd64;

  // Occupancy divider handshake
  typedef struct packed {
    logic             start;
    logic [RUN_W-1:0] kept;
    logic [WORD_W-1:0] total;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [OCC_FRAC-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/seed_position_lookup_unit.sv
`default_nettype none

// Seed position lookup. After reset the key table is swept to "no hits",
// one entry per cycle; configuration writes are taken during the sweep
// but no item is. Key and position writes go to memory at accept and are
// answered with a write-done status. A lookup reads the key entry and
// then the hit count through the registered-read memories, then emits one
// region per cycle from the position store read port while the output is
// not stalled; a trimmed list first passes through the occupancy divider.
// Status results (write done, undefined key, zero hits, offset out of
// range) carry zeros in every span and occupancy field and last set.
module seed_position_lookup_unit
  import spl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  // request channel
  input  wire logic        req_valid,
  output      logic        req_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [15:0] key,
  input  wire logic [17:0] word_addr,
  input  wire logic [39:0] write_value,
  input  wire logic [31:0] query_position,
  // result channel
  output      logic        rsp_valid,
  input  wire logic        rsp_stall,
  output      logic [31:0] region_begin,
  output      logic [31:0] region_end,
  output      logic [31:0] query_begin,
  output      logic [31:0] query_end,
  output      logic [16:0] occupancy,
  output      logic [2:0]  status,
  output      logic        last
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_KEYRD = 3'd2;
  localparam logic [2:0] S_CNTRD = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_STAT  = 3'd6;

  logic [2:0] state;

  // Configuration registers
  logic [5:0] seed_length;
  logic [6:0] max_hits;

  // Memory ports
  logic              key_we;
  logic [KEY_AW-1:0] key_waddr;
  logic [OFS_W-1:0]  key_wdata;
  logic              key_re;
  logic [OFS_W-1:0]  key_rdata;
  logic              pos_we;
  logic              pos_re;
  logic [POS_AW-1:0] pos_raddr;
  logic [WORD_W-1:0] pos_rdata;

  // Per-lookup context
  logic [KEY_AW-1:0] clr_ptr;
  logic [POS_AW-1:0] offset;
  logic [POS_AW-1:0] rd_ptr;
  logic [31:0]       qpos;
  logic [RUN_W-1:0]  kept;
  logic [RUN_W-1:0]  issue_cnt;
  logic [RUN_W-1:0]  emit_cnt;
  logic              dv;
  logic [OCC_W-1:0]  occ;
  logic [2:0]        st_code;

  logic              accept;
  logic              key_ok;
  logic              out_free;
  logic              rsp_valid_next;
  logic              load_stat;
  logic              load_hit;
  logic              issue;
  logic [RUN_W-1:0]  limit;
  logic              trim;
  logic [RUN_W-1:0]  kept_c;
  logic [POS_AW:0]   end_sum;
  logic              range_bad;
  logic [31:0]       len_m1;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // APB register file
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_HITS) ? 32'(max_hits) : 32'(seed_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_length <= SEED_LENGTH_RST;
      max_hits    <= MAX_HITS_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_SEED_LENGTH) begin
        seed_length <= pwdata[5:0];
      end else begin
        max_hits <= pwdata[6:0];
      end
    end
  end

  // Handshake helpers
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign key_ok    = 32'(key) < KEY_DEPTH;

  // Key table: clearing sweep, or key write at accept
  always_comb begin
    if (state == S_CLEAR) begin
      key_we    = 1'b1;
      key_waddr = clr_ptr;
      key_wdata = NO_HITS;
    end else begin
      key_we    = accept && (req_type == REQ_KEY_WR) && key_ok;
      key_waddr = KEY_AW'(key);
      key_wdata = write_value;
    end
  end
  assign key_re = accept && (req_type == REQ_LOOKUP);

  spl_ram #(
    .WIDTH(OFS_W),
    .DEPTH(KEY_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(key_waddr),
    .wdata(key_wdata),
    .re   (key_re),
    .raddr(KEY_AW'(key)),
    .rdata(key_rdata)
  );

  // Position store: count read after the key entry, then the hit run
  assign pos_we = accept && (req_type == REQ_POS_WR) && (32'(word_addr) < POS_DEPTH);
  assign issue  = (state == S_EMIT) && (issue_cnt != kept) && (!dv || out_free);
  assign pos_re = (state == S_KEYRD) || issue;
  assign pos_raddr = (state == S_KEYRD) ? key_rdata[POS_AW-1:0] : rd_ptr;

  spl_ram #(
    .WIDTH(WORD_W),
    .DEPTH(POS_DEPTH)
  ) u_pos_ram (
    .clk  (clk),
    .we   (pos_we),
    .waddr(POS_AW'(word_addr)),
    .wdata(write_value[WORD_W-1:0]),
    .re   (pos_re),
    .raddr(pos_raddr),
    .rdata(pos_rdata)
  );

  // Hit limit, trimming and end-of-run range check on the count word
  always_comb begin
    if (max_hits == 7'd0) begin
      limit = RUN_W'(1);
    end else if (32'(max_hits) > MAX_RUN) begin
      limit = RUN_W'(MAX_RUN);
    end else begin
      limit = RUN_W'(max_hits);
    end
  end
  assign trim      = 32'(limit) < pos_rdata;
  assign kept_c    = trim ? limit : RUN_W'(pos_rdata);
  assign end_sum   = (POS_AW + 1)'(offset) + (POS_AW + 1)'(kept_c);
  assign range_bad = 32'(end_sum) >= POS_DEPTH;

  // Occupancy divider, started only for trimmed runs
  assign div_req.start = (state == S_CNTRD) && (pos_rdata != '0) && !range_bad && trim;
  assign div_req.kept  = kept_c;
  assign div_req.total = pos_rdata;

  spl_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_ptr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + KEY_AW'(1);
          if (clr_ptr == KEY_AW'(KEY_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (req_type)
              REQ_KEY_WR, REQ_POS_WR: begin
                st_code <= ST_WRITE;
                state   <= S_STAT;
              end
              REQ_LOOKUP: begin
                if (key_ok) begin
                  state <= S_KEYRD;
                end else begin
                  st_code <= ST_UNDEF;
                  state   <= S_STAT;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_KEYRD: begin
          offset <= key_rdata[POS_AW-1:0];
          if (key_rdata == NO_HITS) begin
            st_code <= ST_UNDEF;
            state   <= S_STAT;
          end else if (key_rdata >= OFS_W'(POS_DEPTH)) begin
            st_code <= ST_RANGE;
            state   <= S_STAT;
          end else begin
            state <= S_CNTRD;
          end
        end
        S_CNTRD: begin
          kept      <= kept_c;
          rd_ptr    <= offset + POS_AW'(1);
          issue_cnt <= '0;
          emit_cnt  <= '0;
          dv        <= 1'b0;
          occ       <= OCC_ONE;
          if (pos_rdata == '0) begin
            st_code <= ST_ZERO;
            state   <= S_STAT;
          end else if (range_bad) begin
            st_code <= ST_RANGE;
            state   <= S_STAT;
          end else if (trim) begin
            state <= S_DIV;
          end else begin
            state <= S_EMIT;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            occ   <= OCC_W'(div_rsp.quot);
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (issue) begin
            rd_ptr    <= rd_ptr + POS_AW'(1);
            issue_cnt <= issue_cnt + RUN_W'(1);
          end
          dv <= issue ? 1'b1 : (load_hit ? 1'b0 : dv);
          if (load_hit) begin
            emit_cnt <= emit_cnt + RUN_W'(1);
            if (emit_cnt + RUN_W'(1) == kept) begin
              state <= S_IDLE;
            end
          end
        end
        S_STAT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Query position captured at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      qpos <= query_position;
    end
  end

  // Output register
  assign load_stat = (state == S_STAT) && out_free;
  assign load_hit  = (state == S_EMIT) && dv && out_free;
  assign len_m1    = 32'(seed_length) - 32'd1;

  always_comb begin
    if (load_stat || load_hit) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_stat) begin
      region_begin <= '0;
      region_end   <= '0;
      query_begin  <= '0;
      query_end    <= '0;
      occupancy    <= '0;
      status       <= st_code;
      last         <= 1'b1;
    end else if (load_hit) begin
      region_begin <= pos_rdata;
      region_end   <= pos_rdata + len_m1;
      query_begin  <= qpos;
      query_end    <= qpos + len_m1;
      occupancy    <= occ;
      status       <= ST_HIT;
      last         <= (emit_cnt + RUN_W'(1) == kept);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/spl_ram.sv
`default_nettype none

module spl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/spl_div.sv
`default_nettype none

module spl_div
  import spl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output      div_rsp_t rsp
);

  localparam int CNT_W = $clog2(OCC_FRAC + 1);

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [WORD_W:0]     rem;
  logic [WORD_W-1:0]   divisor;
  logic [OCC_FRAC-1:0] quot;
  logic [WORD_W:0]     shifted;
  logic                fits;

  // Restoring step: kept < total, so only the fraction bits are produced
  assign shifted = {rem[WORD_W-1:0], 1'b0};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= (WORD_W + 1)'(req.kept);
      divisor <= req.total;
      cnt     <= CNT_W'(OCC_FRAC);
    end else if (busy) begin
      rem  <= fits ? (shifted - {1'b0, divisor}) : shifted;
      quot <= {quot[OCC_FRAC-2:0], fits};
      cnt  <= cnt - CNT_W'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

`default_nettype wire
